// ===== hw/rtl/ljf_pkg.sv =====
// ============================================================================
// ljf_pkg - longest-job-first scheduler shared definitions
// Sizes of the ready queue and job fields, and the queue entry layout.
// ============================================================================
`default_nettype none

package ljf_pkg;

  // Queue and field sizes
  localparam int QUEUE_DEPTH = 128;
  localparam int ID_BITS     = 8;
  localparam int BURST_BITS  = 16;

  // Pointer into the queue and a count that can hold QUEUE_DEPTH itself
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Port payload widths (fixed by the stream layout)
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  // Command codes carried on in_tuser
  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  // One ready-queue entry
  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic [BURST_BITS-1:0] burst;
  } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/longest_job_first_scheduler.sv =====
// ============================================================================
// longest_job_first_scheduler - non-preemptive longest-burst-first scheduler
// Keeps a ready queue sorted by burst (descending, ties in arrival order) in
// a circular buffer and runs the chosen job one time unit per tick request.
// ============================================================================
//
//  channel | dir | payload                                   | handshake
//  --------+-----+-------------------------------------------+----------------
//  in_     | in  | tuser: command; tdata: process_id, burst  | tvalid/tready
//  out_    | out | tdata: running_id, cpu_busy, job_done,    | tvalid/tready
//          |     |        dropped                            |
//
//  Steps: an arrive runs one S_ARR_RD, S_ARR_CMP pair per queued job with a
//  shorter burst that moves back one place (the insert sweep reads and writes
//  the single queue memory port once per step), then one more pair if it stops
//  at a job whose burst is not shorter, else one S_ARR_RD; a dropped arrive
//  goes to S_FIN; a tick runs S_TICK_RUN, after S_TICK_LD when the head loads.
//  Reset clears the queue count, head pointer and CPU state; the queue memory
//  holds no reset value and needs no clearing pass.
//  One request is in work at a time; a finished response waits in the output
//  register, and the next request may be taken while it waits.
// ============================================================================
`default_nettype none

module longest_job_first_scheduler (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // request channel
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [ljf_pkg::IN_DATA_W-1:0]    in_tdata,  // [7:0] process_id, [23:8] burst_length
  input  wire logic                             in_tuser,  // [0] command
  // response channel
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [ljf_pkg::OUT_DATA_W-1:0]        out_tdata  // [7:0] running_id, [8] cpu_busy,
                                                           // [9] job_done, [10] dropped, rest 0
);
  import ljf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARR_RD,
    S_ARR_CMP,
    S_TICK_LD,
    S_TICK_RUN,
    S_FIN
  } state_t;

  // Control and CPU state
  state_t                 state_r,   state_nxt;
  logic [CNT_W-1:0]       cnt_r,     cnt_nxt;
  logic [PTR_W-1:0]       head_r,    head_nxt;
  logic [CNT_W-1:0]       pos_r,     pos_nxt;
  job_t                   new_r,     new_nxt;
  logic                   busy_r,    busy_nxt;
  logic [ID_BITS-1:0]     cur_id_r,  cur_id_nxt;
  logic [BURST_BITS-1:0]  rem_r,     rem_nxt;

  // Pending response and output register
  logic [7:0]             res_id_r,   res_id_nxt;
  logic                   res_busy_r, res_busy_nxt;
  logic                   res_done_r, res_done_nxt;
  logic                   res_drop_r, res_drop_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r,  out_data_nxt;

  // Queue memory port
  job_t                   mem [QUEUE_DEPTH];
  logic                   wr_en;
  logic [PTR_W-1:0]       wr_addr;
  job_t                   wr_data;
  logic [PTR_W-1:0]       rd_addr;
  job_t                   rd_data_r;

  logic                   in_fire;
  logic [BURST_BITS-1:0]  in_burst;

  // Logical queue position to physical memory address
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                            input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Incoming burst, zero raised to one
  always_comb begin
    in_burst = in_tdata[8 +: BURST_BITS];
    if (in_burst == '0) begin
      in_burst = BURST_BITS'(1);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    pos_nxt       = pos_r;
    new_nxt       = new_r;
    busy_nxt      = busy_r;
    cur_id_nxt    = cur_id_r;
    rem_nxt       = rem_r;
    res_id_nxt    = res_id_r;
    res_busy_nxt  = res_busy_r;
    res_done_nxt  = res_done_r;
    res_drop_nxt  = res_drop_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = head_r;
    wr_data       = new_r;
    rd_addr       = head_r;

    // Output register drains independently
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_id_nxt   = '0;
          res_busy_nxt = 1'b0;
          res_done_nxt = 1'b0;
          res_drop_nxt = 1'b0;
          if (cmd_t'(in_tuser) == CMD_ARRIVE) begin
            new_nxt.id    = in_tdata[ID_BITS-1:0];
            new_nxt.burst = in_burst;
            pos_nxt       = cnt_r;
            if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
              res_drop_nxt = 1'b1;
              state_nxt    = S_FIN;
            end else begin
              state_nxt = S_ARR_RD;
            end
          end else if (!busy_r && cnt_r != '0) begin
            // head entry is being read this cycle
            state_nxt = S_TICK_LD;
          end else begin
            state_nxt = S_TICK_RUN;
          end
        end
      end

      // Walk back from the tail: place the job, or read the entry ahead
      S_ARR_RD: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          wr_addr   = head_r;
          wr_data   = new_r;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_FIN;
        end else begin
          rd_addr   = phys(head_r, PTR_W'(pos_r - CNT_W'(1)));
          state_nxt = S_ARR_CMP;
        end
      end

      // Entry ahead stays if its burst is not shorter, else it moves back
      S_ARR_CMP: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_r, pos_r[PTR_W-1:0]);
        if (rd_data_r.burst >= new_r.burst) begin
          wr_data   = new_r;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_FIN;
        end else begin
          wr_data   = rd_data_r;
          pos_nxt   = pos_r - CNT_W'(1);
          state_nxt = S_ARR_RD;
        end
      end

      // Load the queue head onto the CPU
      S_TICK_LD: begin
        cur_id_nxt = rd_data_r.id;
        rem_nxt    = rd_data_r.burst;
        busy_nxt   = 1'b1;
        head_nxt   = phys(head_r, PTR_W'(1));
        cnt_nxt    = cnt_r - CNT_W'(1);
        state_nxt  = S_TICK_RUN;
      end

      // Run the current job for one time unit
      S_TICK_RUN: begin
        if (busy_r) begin
          rem_nxt      = rem_r - BURST_BITS'(1);
          res_id_nxt   = 8'(cur_id_r);
          res_busy_nxt = 1'b1;
          if (rem_r == BURST_BITS'(1)) begin
            res_done_nxt = 1'b1;
            busy_nxt     = 1'b0;
          end
        end
        state_nxt = S_FIN;
      end

      // Hand the response to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({res_drop_r, res_done_r, res_busy_r, res_id_r});
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      pos_r       <= '0;
      busy_r      <= 1'b0;
      cur_id_r    <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      pos_r       <= pos_nxt;
      busy_r      <= busy_nxt;
      cur_id_r    <= cur_id_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    new_r      <= new_nxt;
    res_id_r   <= res_id_nxt;
    res_busy_r <= res_busy_nxt;
    res_done_r <= res_done_nxt;
    res_drop_r <= res_drop_nxt;
    out_data_r <= out_data_nxt;
  end

  // Ready queue memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_busy_rem: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r != '0)
    else $error("busy CPU with no time left");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ARR_RD || state_r == S_ARR_CMP) |-> pos_r <= cnt_r)
    else $error("insert position past queue tail");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[9]) |-> out_data_r[8])
    else $error("job done reported without a running job");

  a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[10]) |-> (out_data_r[9:0] == '0))
    else $error("dropped response carries run fields");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ============================================================================
// testbench - longest_job_first_scheduler stream-level check
// Drives arrive and tick requests over the input stream and checks each
// response against an in-bench longest-burst-first scheduler model. Both
// stream sides idle at random. The queue is filled past its limit, and the
// output is held off long enough to back up the input.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
  import ljf_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int HOLD_CYCLES = 400;   // long output hold-off
  localparam int TAIL_CYCLES = 300;   // beyond the slowest insert sweep
  localparam int IDLE_PCT    = 31;
  localparam int MAX_PRINTS  = 30;

  // One response as seen on out_tdata (padding bits checked separately)
  typedef struct packed {
    logic                 dropped;
    logic                 job_done;
    logic                 cpu_busy;
    logic [ID_BITS-1:0]   running_id;
  } sched_outcome_t;

  // --------------------------------------------------------------------------
  // Scheduler scoreboard: tracks ready queue and CPU, queues expected outcomes
  // --------------------------------------------------------------------------
  class ljf_scoreboard;
    job_t                  ready_jobs[$];
    logic [ID_BITS-1:0]    cpu_job;
    logic [BURST_BITS-1:0] cpu_left;
    bit                    cpu_running;
    sched_outcome_t        due_outcomes[$];
    int                    errors;
    int                    n_arrive, n_drop, n_tick, n_busy, n_done, n_checked;
    int                    peak_depth;

    // Apply one accepted request to the model state
    function sched_outcome_t schedule_step(cmd_t cmd, logic [ID_BITS-1:0] id,
                                           logic [BURST_BITS-1:0] burst);
      sched_outcome_t o;
      job_t           j;
      int             pos;
      o = '0;
      if (cmd == CMD_ARRIVE) begin
        n_arrive++;
        if (ready_jobs.size() >= QUEUE_DEPTH) begin
          o.dropped = 1'b1;
          n_drop++;
        end else begin
          j.id    = id;
          j.burst = (burst == '0) ? BURST_BITS'(1) : burst;
          // new job goes behind every job with a burst >= its own
          pos = 0;
          while (pos < ready_jobs.size() && ready_jobs[pos].burst >= j.burst) pos++;
          ready_jobs.insert(pos, j);
          if (ready_jobs.size() > peak_depth) peak_depth = ready_jobs.size();
        end
      end else begin
        n_tick++;
        if (!cpu_running && ready_jobs.size() > 0) begin
          j           = ready_jobs.pop_front();
          cpu_job     = j.id;
          cpu_left    = j.burst;
          cpu_running = 1'b1;
        end
        if (cpu_running) begin
          cpu_left     = cpu_left - 1'b1;
          o.running_id = cpu_job;
          o.cpu_busy   = 1'b1;
          n_busy++;
          if (cpu_left == '0) begin
            o.job_done  = 1'b1;
            cpu_running = 1'b0;
            n_done++;
          end
        end
      end
      return o;
    endfunction

    function void log_request(cmd_t cmd, logic [IN_DATA_W-1:0] data);
      due_outcomes.push_back(schedule_step(cmd, data[7:0], data[23:8]));
    endfunction

    task report_mismatch(string what);
      if (errors < MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, what);
      errors++;
    endtask

    task check_outcome(logic [OUT_DATA_W-1:0] data);
      sched_outcome_t want;
      sched_outcome_t got;
      got = data[10:0];
      if (due_outcomes.size() == 0) begin
        report_mismatch($sformatf("response with nothing pending: %h", data));
      end else begin
        want = due_outcomes.pop_front();
        n_checked++;
        if (got.running_id !== want.running_id)
          report_mismatch($sformatf("running_id got %0d want %0d",
                                    got.running_id, want.running_id));
        if (got.cpu_busy !== want.cpu_busy)
          report_mismatch($sformatf("cpu_busy got %b want %b", got.cpu_busy, want.cpu_busy));
        if (got.job_done !== want.job_done)
          report_mismatch($sformatf("job_done got %b want %b", got.job_done, want.job_done));
        if (got.dropped !== want.dropped)
          report_mismatch($sformatf("dropped got %b want %b", got.dropped, want.dropped));
        if (data[OUT_DATA_W-1:11] !== '0)
          report_mismatch($sformatf("padding bits set: %h", data));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [7:0] process_id, [23:8] burst_length
  logic                  in_tuser;   // [0] command
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [7:0] running_id, [8] cpu_busy,
                                     // [9] job_done, [10] dropped

  ljf_scoreboard sb;
  bit            steady_flow;   // no idling on either side while set
  bit            hold_off_req;  // asks the receiver for one long hold-off

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  longest_job_first_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Handshake monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.log_request(cmd_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) sb.check_outcome(out_tdata);
    end
  end

  // Response side: random back-pressure, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end else begin
        out_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driving (called right after a falling edge, returns at one)
  // --------------------------------------------------------------------------
  task send_request(cmd_t cmd, logic [ID_BITS-1:0] id, logic [BURST_BITS-1:0] burst);
    if (!steady_flow) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {burst, id};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task arrive(logic [ID_BITS-1:0] id, logic [BURST_BITS-1:0] burst);
    send_request(CMD_ARRIVE, id, burst);
  endtask

  task tick();
    send_request(CMD_TICK, ID_BITS'($urandom), BURST_BITS'($urandom));
  endtask

  // Sender stops and waits until every response has come back
  task pause_until_drained();
    in_tvalid <= 1'b0;
    while (sb.due_outcomes.size() != 0) @(negedge clk);
  endtask

  // Mostly short jobs, a few zero and longer ones
  function logic [BURST_BITS-1:0] pick_burst();
    int r;
    r = $urandom_range(99);
    if (r < 2)  return '0;
    if (r < 80) return BURST_BITS'($urandom_range(4, 1));
    if (r < 99) return BURST_BITS'($urandom_range(16, 5));
    return BURST_BITS'($urandom_range(64, 17));
  endfunction

  task random_request();
    if ($urandom_range(99) < 80) tick();
    else arrive(ID_BITS'($urandom_range(255)), pick_burst());
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int n;
    sb           = new();
    steady_flow  = 1'b0;
    hold_off_req = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tuser     = CMD_ARRIVE;
    in_tdata     = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: idle tick, zero burst, id extremes, ties, arrive while busy
    tick();
    arrive(8'd0, 16'd0);
    tick();
    tick();
    arrive(8'd255, 16'd3);
    tick();
    arrive(8'd17, 16'd3);
    arrive(8'd18, 16'd5);
    arrive(8'd19, 16'd2);
    arrive(8'd20, 16'd3);
    repeat (15) tick();
    pause_until_drained();

    // Random, no idling on either side
    steady_flow = 1'b1;
    repeat (400) random_request();
    steady_flow = 1'b0;
    pause_until_drained();

    // Random with idling; one long output hold-off while requests keep coming
    for (n = 0; n < 800; n++) begin
      if (n == 300) hold_off_req = 1'b1;
      random_request();
    end
    pause_until_drained();

    // Fill the ready queue, overflow it, then run it empty
    while (sb.ready_jobs.size() < QUEUE_DEPTH)
      arrive(ID_BITS'($urandom_range(255)), BURST_BITS'($urandom_range(3, 1)));
    repeat (3) arrive(ID_BITS'($urandom_range(255)), pick_burst());
    n = 0;
    while ((sb.ready_jobs.size() > 0 || sb.cpu_running) && n < 1500) begin
      tick();
      n++;
    end
    pause_until_drained();

    // Wide bursts last: these never finish within the run
    arrive(8'd255, 16'hFFFF);
    arrive(ID_BITS'($urandom_range(255)), 16'h8000 | BURST_BITS'($urandom));
    arrive(8'd0, 16'h7FFF);
    repeat (30) tick();

    // Drain and let any stray response show up
    in_tvalid <= 1'b0;
    while (sb.due_outcomes.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d requests: %0d arrivals (%0d dropped), %0d ticks (%0d busy).",
             sb.n_checked, sb.n_arrive, sb.n_drop, sb.n_tick, sb.n_busy);
    $display("Jobs finished: %0d, deepest ready queue: %0d, mismatches: %0d.",
             sb.n_done, sb.peak_depth, sb.errors);
    if (sb.errors == 0 && sb.due_outcomes.size() == 0) begin
      $display("longest_job_first_scheduler: match");
    end else begin
      $display("longest_job_first_scheduler: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond a slow run with full-depth insert sweeps and stalls
  initial begin
    #40_000_000;
    $display("Timeout waiting for the scheduler.");
    $display("longest_job_first_scheduler: mismatch");
    $finish;
  end

endmodule
